FILE: src/slstk_pkg.sv
// ----------------------------------------------------------------------------
// slstk_pkg: shared types and constants
// Widths, command codes and controller/datapath command structs.
// ----------------------------------------------------------------------------
`default_nettype none
package slstk_pkg;
   localparam int NumModels    = 4;
   localparam int FeatureBits  = 16;
   localparam int TopK         = 64;
   localparam int ModelBits    = 2;
   localparam int RankBits     = 6;
   localparam int FillBits     = 7;
   localparam int ScoreBits    = 48;
   localparam int OffsetBits   = 31;
   localparam int SourceBits   = 16;
   localparam int ListBits     = ModelBits + RankBits;

   localparam logic signed [ScoreBits-1:0] ThreshReset = -48'sd65470464;
   localparam logic signed [ScoreBits-1:0] ScoreMax = {1'b0, {(ScoreBits-1){1'b1}}};
   localparam logic signed [ScoreBits-1:0] ScoreMin = {1'b1, {(ScoreBits-1){1'b0}}};

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_FEATURE = 2'd1,
      CMD_END = 2'd2,
      CMD_READ = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]           cmd;
      logic [ModelBits-1:0] model_index;
      logic [15:0]          feature_index;
      logic signed [31:0]   sample_value;
      logic [30:0]          doc_offset;
      logic [15:0]          source_tag;
      logic [RankBits-1:0]  rank;
   } req_type;

   typedef struct packed {
      logic [3:0]                  accepted_mask;
      logic signed [ScoreBits-1:0] entry_score;
      logic [OffsetBits-1:0]       entry_offset;
      logic [SourceBits-1:0]       entry_source;
      logic                        entry_valid;
      logic [FillBits-1:0]         stored_count;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic                 capture;    // latch request
      logic                 wr_weight;  // write weight table
      logic                 rd_weight;  // read weight for lane
      logic [ModelBits-1:0] lane;
      logic                 ins_start;  // begin insert for lane
      logic                 clr_scores;
      logic                 rd_entry;   // issue list read
      logic                 rsp_load;   // build response
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic ins_done;
      logic [1:0] cmd;
   } dp_sts_type;
endpackage
`default_nettype wire

FILE: src/slstk_if.sv
// ----------------------------------------------------------------------------
// slstk_if: valid/ready channel
// Carries one word of payload with a source and a sink side.
// ----------------------------------------------------------------------------
`default_nettype none
interface slstk_req_if;
   logic valid;
   logic ready;
   slstk_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface slstk_rsp_if;
   logic valid;
   logic ready;
   slstk_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/sparse_linear_score_top_k_top.sv
// ----------------------------------------------------------------------------
// sparse_linear_score_top_k_top: sparse linear scoring with top-K lists
// Req words carry load/feature/end/read commands; each gives one rsp word.
// csr_we/csr_wdata set the active lane count; write it only when idle.
// One word at a time: req_ready is high only while nothing is in flight.
// Load and read: after the req handshake the block steps through dispatch,
// reply-build and output states, and rsp_valid is high in the last of them.
// Feature: one lane per cycle through a 3-stage read-multiply-accumulate,
// over the active lanes, then a drain state before the reply is built.
// End of document: lanes in turn, each walking its sorted list one entry
// at a time, then scores are cleared. After reset a sweep over all 2^18
// weight addresses zeroes the weight memory; req_ready stays low until it
// ends. A stalled rsp holds the block in its reply state and req_ready
// stays low until the rsp word is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module sparse_linear_score_top_k_top (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  csr_we,
   input  wire logic [2:0] csr_wdata,
   slstk_req_if.sink  req,
   slstk_rsp_if.source rsp
);
   logic [2:0] am_ff;
   slstk_pkg::dp_cmd_type c;
   slstk_pkg::dp_sts_type s;
   typedef enum logic [2:0] {S_SWEEP, S_IDLE, S_DISP, S_FEAT, S_DRAIN, S_INS, S_RSP, S_OUT}
      st_type;
   st_type st_ff;
   logic [2:0] ln_ff;
   logic [18:0] sw_ff;
   logic busy_ff;
   logic [2:0] lim;

   always_ff @(posedge clock) begin
      if (reset) am_ff <= 3'd4;
      else if (csr_we) am_ff <= csr_wdata;
   end

   assign req.ready = (st_ff == S_IDLE);
   assign rsp.valid = (st_ff == S_OUT);
   assign lim = (am_ff > 3'd4) ? 3'd4 : am_ff;

   always_comb begin
      c = '0;
      c.capture = req.valid && req.ready;
      c.lane = ln_ff[1:0];
      if (st_ff == S_DISP && s.cmd == slstk_pkg::CMD_LOAD) c.wr_weight = 1'b1;
      if (st_ff == S_FEAT && ln_ff < lim) c.rd_weight = 1'b1;
      if (st_ff == S_INS && ln_ff[2] == 1'b0 && !busy_ff) c.ins_start = 1'b1;
      if (st_ff == S_DISP && s.cmd == slstk_pkg::CMD_READ) c.rd_entry = 1'b1;
      if (st_ff == S_RSP) c.rsp_load = 1'b1;
      if (st_ff == S_INS && ln_ff == 3'd4) c.clr_scores = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_SWEEP; sw_ff <= '0; busy_ff <= 1'b0;
      end else begin
         unique case (st_ff)
            S_SWEEP: begin
               sw_ff <= sw_ff + 1'b1;
               if (sw_ff[18]) st_ff <= S_IDLE;
            end
            S_IDLE: if (req.valid) st_ff <= S_DISP;
            S_DISP: begin
               ln_ff <= '0;
               unique case (s.cmd)
                  slstk_pkg::CMD_FEATURE: st_ff <= S_FEAT;
                  slstk_pkg::CMD_END: st_ff <= S_INS;
                  default: st_ff <= S_RSP;
               endcase
            end
            S_FEAT: begin
               if (ln_ff + 1'b1 >= lim || ln_ff == 3'd3) begin
                  st_ff <= S_DRAIN; ln_ff <= '0;
               end else ln_ff <= ln_ff + 1'b1;
               if (lim == 3'd0) st_ff <= S_DRAIN;
            end
            S_DRAIN: begin
               ln_ff <= ln_ff + 1'b1;
               if (ln_ff == 3'd2) st_ff <= S_RSP;
            end
            S_INS: begin
               if (ln_ff == 3'd4) st_ff <= S_RSP;
               else if (!busy_ff) busy_ff <= 1'b1;
               else if (s.ins_done) begin
                  busy_ff <= 1'b0; ln_ff <= ln_ff + 1'b1;
               end
            end
            S_RSP: st_ff <= S_OUT;
            S_OUT: if (rsp.ready) st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   slstk_datapath u_dp (
      .clock(clock), .reset(reset), .active_models(am_ff),
      .req_data(req.data), .cmd(c), .sts(s), .rsp_data(rsp.data)
   );

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("both sides open");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("rsp dropped");
   a_clr: assert property (@(posedge clock) disable iff (reset)
      c.clr_scores |-> st_ff == S_INS) else $error("bad clear");
endmodule
`default_nettype wire

FILE: src/slstk_datapath.sv
// ----------------------------------------------------------------------------
// slstk_datapath: weights, accumulators and top-K lists
// Weight memory, per-lane multiply-accumulate, list insert by stepping.
// ----------------------------------------------------------------------------
`default_nettype none
module slstk_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [2:0]             active_models,
   input  wire slstk_pkg::req_type     req_data,
   input  wire slstk_pkg::dp_cmd_type  cmd,
   output slstk_pkg::dp_sts_type       sts,
   output slstk_pkg::rsp_type          rsp_data
);
   localparam int WAddrBits = slstk_pkg::ModelBits + slstk_pkg::FeatureBits;
   localparam int SB = slstk_pkg::ScoreBits;

   slstk_pkg::req_type r_ff;

   // weight memory, zeroed by a sweep over every address after reset
   logic [31:0] wmem [2**WAddrBits];
   logic signed [31:0] wrd_ff;
   logic signed [63:0] prod_ff;
   logic                prod_v_ff;
   logic [slstk_pkg::ModelBits-1:0] prod_lane_ff;
   logic [slstk_pkg::ModelBits-1:0] rd_lane_ff;
   logic rd_v_ff;
   logic [WAddrBits:0] sweep_ff;
   logic sweeping;

   logic signed [SB-1:0] acc_ff [slstk_pkg::NumModels];
   logic signed [SB-1:0] thr_ff [slstk_pkg::NumModels];
   logic [slstk_pkg::FillBits-1:0] fill_ff [slstk_pkg::NumModels];
   logic [3:0] mask_ff;

   // lists: one memory each for score, offset, source
   logic [SB-1:0] lscore [2**slstk_pkg::ListBits];
   logic [slstk_pkg::OffsetBits-1:0] loff [2**slstk_pkg::ListBits];
   logic [slstk_pkg::SourceBits-1:0] lsrc [2**slstk_pkg::ListBits];
   logic [SB-1:0] qs_ff;
   logic [slstk_pkg::OffsetBits-1:0] qo_ff;
   logic [slstk_pkg::SourceBits-1:0] qq_ff;

   // Insert walk: a growing list from the top downward, carrying entries up, a full
   // one from rank 0 upward, carrying entries down, until the new score's slot is found.
   typedef enum logic [2:0] {I_IDLE, I_READ, I_WAIT, I_TEST, I_DONE, I_THR} ins_type;
   ins_type ist_ff;
   logic [slstk_pkg::ModelBits-1:0] il_ff;
   logic [slstk_pkg::FillBits-1:0]  ip_ff;    // write slot of the walk
   logic                            full_ff;
   logic                            acc_ok_ff;
   logic signed [SB-1:0]            ns_ff;    // new score

   logic [WAddrBits-1:0] waddr;
   logic [WAddrBits-1:0] raddr;
   logic [slstk_pkg::ListBits-1:0] laddr;
   logic [2:0] lim;
   logic signed [SB+1:0] sum;
   logic signed [SB-1:0] psh;

   logic [slstk_pkg::FillBits-1:0] probe;
   logic fwe;
   logic [slstk_pkg::ListBits-1:0] fwaddr;
   logic [SB-1:0] fwscore;
   logic [slstk_pkg::OffsetBits-1:0] fwoff;
   logic [slstk_pkg::SourceBits-1:0] fwsrc;
   logic shift_more;
   logic probe_end;

   // per-lane lowest score, mirrored in flops on every write to rank 0
   logic signed [SB-1:0] low_ff [slstk_pkg::NumModels];
   logic signed [SB-1:0] lscore0;

   slstk_pkg::rsp_type rsp_in;

   assign lim = (active_models > 3'(slstk_pkg::NumModels)) ?
                3'(slstk_pkg::NumModels) : active_models;
   assign waddr = {r_ff.model_index, r_ff.feature_index};
   assign raddr = {cmd.lane, r_ff.feature_index};
   assign sweeping = !sweep_ff[WAddrBits];

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (sweeping) begin
         sweep_ff <= sweep_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) r_ff <= req_data;
      if (sweeping) wmem[sweep_ff[WAddrBits-1:0]] <= '0;
      else if (cmd.wr_weight) wmem[waddr] <= r_ff.sample_value;
      if (cmd.rd_weight) wrd_ff <= wmem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= cmd.rd_weight;
         rd_lane_ff <= cmd.lane;
         prod_v_ff <= rd_v_ff;
         prod_lane_ff <= rd_lane_ff;
      end
      if (rd_v_ff) prod_ff <= 64'(wrd_ff) * 64'(r_ff.sample_value);
   end

   assign psh = SB'(prod_ff >>> 16);
   assign sum = (SB+2)'(acc_ff[prod_lane_ff]) + (SB+2)'(psh);

   // list read port for the read command
   assign laddr = {r_ff.model_index, r_ff.rank};

   // growing list walk: ip is the free slot; probe ip-1.
   // full list walk: ip goes up from 0; slot ip gets entry ip+1 while it is
   // below the new score; then the new score lands at ip.
   assign probe = full_ff ? ip_ff + 1'b1 : ip_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.rd_entry) begin
         qs_ff <= lscore[laddr]; qo_ff <= loff[laddr]; qq_ff <= lsrc[laddr];
      end else if (ist_ff == I_READ) begin
         qs_ff <= lscore[{il_ff, probe[slstk_pkg::RankBits-1:0]}];
         qo_ff <= loff[{il_ff, probe[slstk_pkg::RankBits-1:0]}];
         qq_ff <= lsrc[{il_ff, probe[slstk_pkg::RankBits-1:0]}];
      end
      if (fwe) begin
         lscore[fwaddr] <= fwscore; loff[fwaddr] <= fwoff; lsrc[fwaddr] <= fwsrc;
      end
   end

   always_comb begin
      fwe = 1'b0;
      fwaddr = {il_ff, ip_ff[slstk_pkg::RankBits-1:0]};
      fwscore = ns_ff; fwoff = r_ff.doc_offset; fwsrc = r_ff.source_tag;
      shift_more = 1'b0;
      if (full_ff) probe_end = (ip_ff + 1'b1) >= 7'(slstk_pkg::TopK);
      else         probe_end = (ip_ff == '0);
      if (ist_ff == I_TEST) begin
         if (!probe_end && (full_ff ? ($signed(qs_ff) < ns_ff)
                                    : ($signed(qs_ff) >= ns_ff))) begin
            shift_more = 1'b1;
            fwscore = qs_ff; fwoff = qo_ff; fwsrc = qq_ff;
         end
         fwe = acc_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ist_ff <= I_IDLE;
         mask_ff <= '0;
         for (int m = 0; m < slstk_pkg::NumModels; m++) begin
            acc_ff[m] <= '0;
            thr_ff[m] <= slstk_pkg::ThreshReset;
            fill_ff[m] <= '0;
         end
      end else begin
         if (prod_v_ff) begin
            if (sum > (SB+2)'(slstk_pkg::ScoreMax))
               acc_ff[prod_lane_ff] <= slstk_pkg::ScoreMax;
            else if (sum < (SB+2)'(slstk_pkg::ScoreMin))
               acc_ff[prod_lane_ff] <= slstk_pkg::ScoreMin;
            else acc_ff[prod_lane_ff] <= SB'(sum);
         end
         if (cmd.capture) mask_ff <= '0;
         unique case (ist_ff)
            I_IDLE: begin
               if (cmd.ins_start) begin
                  il_ff <= cmd.lane;
                  ns_ff <= acc_ff[cmd.lane];
                  full_ff <= fill_ff[cmd.lane] >= 7'(slstk_pkg::TopK);
                  ip_ff <= (fill_ff[cmd.lane] >= 7'(slstk_pkg::TopK)) ? '0 : fill_ff[cmd.lane];
                  if (3'(cmd.lane) < lim && acc_ff[cmd.lane] > thr_ff[cmd.lane]) begin
                     acc_ok_ff <= 1'b1;
                     ist_ff <= I_READ;
                     mask_ff[cmd.lane] <= 1'b1;
                  end else begin
                     acc_ok_ff <= 1'b0;
                     ist_ff <= I_DONE;
                  end
               end
            end
            I_READ: begin
               // full list: new lowest is dropped outright
               if (full_ff && !(lscore0 < ns_ff)) ist_ff <= I_DONE;
               else if (!full_ff && ip_ff == '0) ist_ff <= I_TEST;
               else ist_ff <= I_WAIT;
            end
            I_WAIT: ist_ff <= I_TEST;
            I_TEST: begin
               if (shift_more) begin
                  ip_ff <= full_ff ? ip_ff + 1'b1 : ip_ff - 1'b1;
                  ist_ff <= I_READ;
               end else begin
                  if (!full_ff) fill_ff[il_ff] <= fill_ff[il_ff] + 1'b1;
                  ist_ff <= I_DONE;
               end
            end
            I_DONE: ist_ff <= I_THR;
            I_THR: begin
               if (fill_ff[il_ff] >= 7'(slstk_pkg::TopK)) thr_ff[il_ff] <= lscore0;
               ist_ff <= I_IDLE;
            end
            default: ist_ff <= I_IDLE;
         endcase
         if (cmd.clr_scores)
            for (int m = 0; m < slstk_pkg::NumModels; m++) acc_ff[m] <= '0;
      end
   end

   assign lscore0 = low_ff[il_ff];
   always_ff @(posedge clock) begin
      if (fwe && fwaddr[slstk_pkg::RankBits-1:0] == '0) low_ff[il_ff] <= fwscore;
   end

   assign sts.ins_done = (ist_ff == I_THR);
   assign sts.cmd = r_ff.cmd;

   always_comb begin
      rsp_in = '0;
      if (r_ff.cmd == slstk_pkg::CMD_END) rsp_in.accepted_mask = mask_ff;
      if (r_ff.cmd == slstk_pkg::CMD_READ &&
          32'(r_ff.model_index) < slstk_pkg::NumModels) begin
         rsp_in.stored_count = fill_ff[r_ff.model_index];
         if (7'(r_ff.rank) < fill_ff[r_ff.model_index]) begin
            rsp_in.entry_valid = 1'b1;
            rsp_in.entry_score = qs_ff;
            rsp_in.entry_offset = qo_ff;
            rsp_in.entry_source = qq_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) rsp_data <= rsp_in;
   end
endmodule
`default_nettype wire

FILE: tb/slstk_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slstk_tb_pkg: scoring and top-K list predictor
// Tracks weights, running scores, thresholds and lists; gives the reply word.
// ----------------------------------------------------------------------------
package slstk_tb_pkg;
   import slstk_pkg::*;

   typedef logic signed [ScoreBits-1:0] score_type;

   // sparse weight store: only written entries are kept, others read as zero
   logic signed [31:0] weight_mem [int unsigned];
   score_type          acc [NumModels];
   score_type          thresh [NumModels];
   score_type          top_score [NumModels][TopK];
   logic [30:0]        top_offset [NumModels][TopK];
   logic [15:0]        top_source [NumModels][TopK];
   int unsigned        top_fill [NumModels];
   int unsigned        lanes_used;

   function automatic void score_reset();
      weight_mem.delete();
      lanes_used = 4;
      for (int m = 0; m < NumModels; m++) begin
         acc[m] = '0;
         thresh[m] = ThreshReset;
         top_fill[m] = 0;
      end
   endfunction

   function automatic void score_set_lanes(logic [2:0] v);
      lanes_used = (v > NumModels) ? NumModels : v;
   endfunction

   function automatic score_type sat_add(score_type a, logic signed [63:0] p);
      logic signed [63:0] s;
      s = 64'(a) + p;
      if (s > 64'(ScoreMax)) return ScoreMax;
      if (s < 64'(ScoreMin)) return ScoreMin;
      return s[ScoreBits-1:0];
   endfunction

   function automatic bit list_insert(int m, score_type sc, logic [30:0] off,
                                      logic [15:0] src);
      int pos;
      int n;
      n = top_fill[m];
      pos = 0;
      if (sc <= thresh[m]) return 0;
      while (pos < n && top_score[m][pos] < sc) pos++;
      if (n < TopK) begin
         for (int i = n; i > pos; i--) begin
            top_score[m][i] = top_score[m][i-1];
            top_offset[m][i] = top_offset[m][i-1];
            top_source[m][i] = top_source[m][i-1];
         end
         top_score[m][pos] = sc;
         top_offset[m][pos] = off;
         top_source[m][pos] = src;
         n++;
         top_fill[m] = n;
      end else if (pos > 0) begin
         for (int i = 0; i + 1 < pos; i++) begin
            top_score[m][i] = top_score[m][i+1];
            top_offset[m][i] = top_offset[m][i+1];
            top_source[m][i] = top_source[m][i+1];
         end
         top_score[m][pos-1] = sc;
         top_offset[m][pos-1] = off;
         top_source[m][pos-1] = src;
      end
      if (n >= TopK) thresh[m] = top_score[m][0];
      return 1;
   endfunction

   function automatic rsp_type score_step(req_type r);
      rsp_type o;
      logic signed [63:0] prod;
      logic signed [31:0] w;
      o = '0;
      case (cmd_type'(r.cmd))
         CMD_LOAD: weight_mem[{r.model_index, r.feature_index}] = r.sample_value;
         CMD_FEATURE: begin
            for (int m = 0; m < lanes_used; m++) begin
               w = weight_mem.exists({m[1:0], r.feature_index}) ?
                   weight_mem[{m[1:0], r.feature_index}] : 32'sd0;
               prod = (64'(w) * 64'(r.sample_value)) >>> 16;
               acc[m] = sat_add(acc[m], prod);
            end
         end
         CMD_END: begin
            for (int m = 0; m < lanes_used; m++)
               if (list_insert(m, acc[m], r.doc_offset, r.source_tag))
                  o.accepted_mask[m] = 1'b1;
            for (int m = 0; m < NumModels; m++) acc[m] = '0;
         end
         default: begin
            o.stored_count = 7'(top_fill[r.model_index]);
            if (r.rank < top_fill[r.model_index]) begin
               o.entry_score = top_score[r.model_index][r.rank];
               o.entry_offset = top_offset[r.model_index][r.rank];
               o.entry_source = top_source[r.model_index][r.rank];
               o.entry_valid = 1'b1;
            end
         end
      endcase
      return o;
   endfunction
endpackage

FILE: tb/sparse_linear_score_top_k_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_linear_score_top_k_top_tb: self-checking bench
// Directed table then random documents; replies are checked field by field
// against a predictor, with random bursts, stalls and lane-count changes.
// ----------------------------------------------------------------------------
module sparse_linear_score_top_k_top_tb;
   import slstk_pkg::*;
   import slstk_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [2:0] csr_wdata = 3'd4;

   slstk_req_if req_ch ();
   slstk_rsp_if rsp_ch ();

   sparse_linear_score_top_k_top DUT (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req(req_ch.sink), .rsp(rsp_ch.source)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // one directed row: word plus optional typed-in reply
   typedef struct {
      req_type word;
      bit      known;
      rsp_type want;
   } row_type;

   rsp_type     reply_q [$];
   int          errors = 0;
   int          words_sent = 0;
   int          replies_seen = 0;
   int          inserts_seen = 0;
   longint      cycles = 0;
   bit          long_hold = 0;
   bit          hold_used = 0;
   int          wr_lane = 0;

   // watchdog: covers the weight sweep plus worst-case inserts, stalls, gaps
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 64'd12_000_000) begin
         $display("** sparse_linear_score_top_k_top: FAILED **");
         $finish;
      end
   end

   // receiver: own stall pattern, plus one long hold-off
   initial begin
      int hold;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold && !hold_used) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_used = 1;
         end else begin
            case ($urandom_range(0, 3))
               0: rsp_ch.ready <= 1'b0;
               default: rsp_ch.ready <= 1'b1;
            endcase
            hold = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : 1;
            repeat (hold) @(negedge clock);
         end
      end
   end

   // checker: sample at rising edge
   always @(posedge clock) begin
      rsp_type exp_w;
      rsp_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         replies_seen++;
         if (reply_q.size() == 0) begin
            $error("unexpected reply word %h", got);
            errors++;
         end else begin
            exp_w = reply_q.pop_front();
            if (got.accepted_mask != 0) inserts_seen++;
            if (got.accepted_mask !== exp_w.accepted_mask) begin
               $error("accepted_mask exp %h got %h", exp_w.accepted_mask, got.accepted_mask);
               errors++;
            end
            if (got.entry_score !== exp_w.entry_score) begin
               $error("entry_score exp %0d got %0d", exp_w.entry_score, got.entry_score);
               errors++;
            end
            if (got.entry_offset !== exp_w.entry_offset) begin
               $error("entry_offset exp %h got %h", exp_w.entry_offset, got.entry_offset);
               errors++;
            end
            if (got.entry_source !== exp_w.entry_source) begin
               $error("entry_source exp %h got %h", exp_w.entry_source, got.entry_source);
               errors++;
            end
            if (got.entry_valid !== exp_w.entry_valid) begin
               $error("entry_valid exp %b got %b", exp_w.entry_valid, got.entry_valid);
               errors++;
            end
            if (got.stored_count !== exp_w.stored_count) begin
               $error("stored_count exp %0d got %0d", exp_w.stored_count, got.stored_count);
               errors++;
            end
         end
      end
   end

   // drive one word at negedge; hold until accepted
   task automatic send_word(req_type w, bit known, rsp_type want);
      rsp_type p;
      p = score_step(w);
      if (known && p !== want) begin
         $error("table row disagrees with predictor: exp %h pred %h", want, p);
         errors++;
      end
      reply_q.push_back(p);
      req_ch.data <= w;
      req_ch.valid <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic idle_gap(int n);
      req_ch.valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // wait for all replies, then let the insert walk settle before a csr write
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (reply_q.size() != 0) @(negedge clock);
      repeat (4 * 3 * TopK + 20) @(negedge clock);
   endtask

   task automatic write_lanes(logic [2:0] v);
      csr_wdata <= v;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      score_set_lanes(v);
   endtask

   function automatic req_type mk(cmd_type c, int mi, int fi, int sv, int off, int src, int rk);
      req_type w;
      w.cmd = c;
      w.model_index = 2'(mi);
      w.feature_index = 16'(fi);
      w.sample_value = sv;
      w.doc_offset = 31'(off);
      w.source_tag = 16'(src);
      w.rank = 6'(rk);
      return w;
   endfunction

   // random word; most words form documents over a small feature set
   function automatic req_type rand_word();
      req_type w;
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      w = raw[$bits(req_type)-1:0];
      case ($urandom_range(0, 19))
         0, 1: w.cmd = CMD_LOAD;
         2, 3, 4, 5, 6, 7, 8, 9, 10, 11: w.cmd = CMD_FEATURE;
         12, 13, 14: w.cmd = CMD_END;
         default: w.cmd = CMD_READ;
      endcase
      if ($urandom_range(0, 3) != 0) w.feature_index = 16'($urandom_range(0, 31));
      if (w.cmd == CMD_FEATURE && $urandom_range(0, 2) != 0)
         w.sample_value = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0001_0000;
      if (w.cmd == CMD_READ && $urandom_range(0, 1) == 0)
         w.rank = 6'($urandom_range(0, 8));
      if (w.cmd == CMD_READ && w.rank >= top_fill[w.model_index] && $urandom_range(0, 3) != 0)
         w.rank = top_fill[w.model_index] == 0 ? w.rank :
                  6'($urandom_range(0, top_fill[w.model_index] - 1));
      return w;
   endfunction

   row_type dir_tab [$];

   initial begin
      rsp_type r0;
      rsp_type z;
      req_type w;
      int burst;
      int lane_set [5] = '{1, 4, 7, 0, 2};
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      score_reset();
      z = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed: empty reads, extremes of weights and values, end cases
      r0 = z;
      dir_tab.push_back('{mk(CMD_READ, 0, 0, 0, 0, 0, 0), 1, r0});
      dir_tab.push_back('{mk(CMD_READ, 3, 0, 0, 0, 0, 63), 1, r0});
      dir_tab.push_back('{mk(CMD_END, 0, 0, 0, 0, 0, 0), 1, '{4'hf, 0, 0, 0, 0, 0}});
      dir_tab.push_back('{mk(CMD_LOAD, 0, 0, 32'h7fffffff, 0, 0, 0), 1, z});
      dir_tab.push_back('{mk(CMD_LOAD, 1, 0, 32'h80000000, 0, 0, 0), 1, z});
      dir_tab.push_back('{mk(CMD_LOAD, 2, 65535, 32'h00010000, 0, 0, 0), 1, z});
      dir_tab.push_back('{mk(CMD_LOAD, 3, 65535, 32'hffff0000, 0, 0, 0), 1, z});
      dir_tab.push_back('{mk(CMD_FEATURE, 0, 0, 32'h7fffffff, 0, 0, 0), 0, z});
      dir_tab.push_back('{mk(CMD_FEATURE, 0, 0, 32'h7fffffff, 0, 0, 0), 0, z});
      dir_tab.push_back('{mk(CMD_FEATURE, 0, 0, 32'h7fffffff, 0, 0, 0), 0, z});
      dir_tab.push_back('{mk(CMD_FEATURE, 0, 0, 32'h7fffffff, 0, 0, 0), 0, z});
      dir_tab.push_back('{mk(CMD_FEATURE, 0, 65535, 32'h80000000, 0, 0, 0), 0, z});
      dir_tab.push_back('{mk(CMD_END, 0, 0, 0, 31'h7fffffff, 16'hffff, 0), 0, z});
      dir_tab.push_back('{mk(CMD_READ, 0, 0, 0, 0, 0, 0), 0, z});
      dir_tab.push_back('{mk(CMD_READ, 1, 0, 0, 0, 0, 0), 0, z});
      dir_tab.push_back('{mk(CMD_READ, 3, 0, 0, 0, 0, 1), 0, z});
      dir_tab.push_back('{mk(CMD_END, 0, 0, 0, 5, 6, 0), 0, z});  // tie at zero
      dir_tab.push_back('{mk(CMD_READ, 2, 0, 0, 0, 0, 0), 0, z});
      dir_tab.push_back('{mk(CMD_READ, 2, 0, 0, 0, 0, 1), 0, z});
      dir_tab.push_back('{mk(CMD_FEATURE, 0, 0, 32'h00000001, 0, 0, 0), 0, z});
      dir_tab.push_back('{mk(CMD_END, 0, 0, 0, 1, 1, 0), 0, z});

      foreach (dir_tab[i]) begin
         send_word(dir_tab[i].word, dir_tab[i].known, dir_tab[i].want);
         if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 4));
      end

      // random phases over several lane counts
      foreach (lane_set[p]) begin
         drain();
         write_lanes(3'(lane_set[p]));
         for (int n = 0; n < 380; ) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && n < 380; b++, n++) begin
               if (p == 1 && n == 100) long_hold = 1;  // block fills and stalls req
               w = rand_word();
               send_word(w, 0, z);
            end
            if (p == 2 && n >= 200 && n < 225) begin
               req_ch.valid <= 1'b0;  // sender waits out every reply
               while (reply_q.size() != 0) @(negedge clock);
            end
            if ($urandom_range(0, 4) != 0) idle_gap($urandom_range(1, 12));
         end
      end

      drain();
      $display("sent %0d words, checked %0d replies, %0d with inserts, long hold %0d",
               words_sent, replies_seen, inserts_seen, hold_used);
      if (errors == 0 && reply_q.size() == 0) begin
         $display("** sparse_linear_score_top_k_top: PASSED **");
      end else begin
         $display("** sparse_linear_score_top_k_top: FAILED **");
      end
      $finish;
   end
endmodule

FILE: sim.f
src/slstk_pkg.sv
src/slstk_if.sv
src/slstk_datapath.sv
src/sparse_linear_score_top_k_top.sv
tb/slstk_tb_pkg.sv
tb/sparse_linear_score_top_k_top_tb.sv
